// ===== src/vau_pkg.sv =====
// Shared types, constants and saturation helper for the vector arithmetic unit.
// No dependencies; every other file imports this package.
package vau_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SQRT_STAGES   = 32;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [64:0] SAT_HI  = 65'sd2147483647;
    localparam logic signed [64:0] SAT_LO  = -65'sd2147483648;

    typedef enum logic [3:0] {
        CMD_ADD       = 4'd0,
        CMD_SUB       = 4'd1,
        CMD_MUL       = 4'd2,
        CMD_DIV       = 4'd3,
        CMD_DOT       = 4'd4,
        CMD_CROSS     = 4'd5,
        CMD_SCALE     = 4'd6,
        CMD_DIVSCALAR = 4'd7,
        CMD_LENGTH    = 4'd8,
        CMD_NORMALIZE = 4'd9,
        CMD_EQUAL     = 4'd10
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ov;
    } sat_t;

    typedef struct packed {
        logic signed [31:0] q;
        logic               dz;
        logic               ov;
    } div_res_t;

    function automatic sat_t sat65(input logic signed [64:0] v);
        sat_t r;
        if (v > SAT_HI)
        begin
            r.val = S32_MAX;
            r.ov  = 1'b1;
        end
        else if (v < SAT_LO)
        begin
            r.val = S32_MIN;
            r.ov  = 1'b1;
        end
        else
        begin
            r.val = v[31:0];
            r.ov  = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== src/vau_lane.sv =====
// One component lane: multiplier pair, add/sub and the saturated per-component result.
// Depends on vau_pkg.
module vau_lane import vau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  cmd_t               cmd,
    input  logic signed [31:0] ai,
    input  logic signed [31:0] bi,
    input  logic signed [31:0] aj,
    input  logic signed [31:0] bj,
    input  logic signed [31:0] am,
    input  logic signed [31:0] bm,
    input  logic signed [31:0] k,
    output logic signed [63:0] prod,
    output sat_t               res
);

    logic signed [31:0] mul_l;
    logic signed [31:0] mul_r;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] cprod_reg, cprod_next;
    logic signed [32:0] sum_reg, sum_next;
    cmd_t               cmd_reg;
    sat_t               res_reg, res_next;
    logic signed [64:0] diff;
    logic signed [64:0] pick;

    always_comb
    begin
        mul_l = (cmd == CMD_CROSS) ? aj : ai;
        case (cmd)
            CMD_MUL, CMD_DOT: mul_r = bi;
            CMD_SCALE:        mul_r = k;
            CMD_CROSS:        mul_r = bm;
            default:          mul_r = ai;
        endcase
        prod_next  = mul_l * mul_r;
        cprod_next = am * bj;
        if (cmd == CMD_SUB)
            sum_next = {ai[31], ai} - {bi[31], bi};
        else
            sum_next = {ai[31], ai} + {bi[31], bi};
    end

    always_comb
    begin
        diff = {prod_reg[63], prod_reg} - {cprod_reg[63], cprod_reg};
        case (cmd_reg)
            CMD_ADD, CMD_SUB:   pick = {{32{sum_reg[32]}}, sum_reg};
            CMD_MUL, CMD_SCALE: pick = $signed({prod_reg[63], prod_reg}) >>> FRAC_BITS;
            CMD_CROSS:          pick = diff >>> FRAC_BITS;
            default:            pick = '0;
        endcase
        res_next = sat65(pick);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            cprod_reg <= cprod_next;
            sum_reg   <= sum_next;
            cmd_reg   <= cmd;
            res_reg   <= res_next;
        end
    end

    assign prod = prod_reg;
    assign res  = res_reg;

endmodule

// ===== src/vau_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on vau_pkg.
module vau_sqrt import vau_pkg::*; (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [31:0] root
);

    localparam int RW = 34;

    logic [RW-1:0] rem_reg   [SQRT_STAGES];
    logic [31:0]   root_reg  [SQRT_STAGES];
    logic [63:0]   rad_reg   [SQRT_STAGES];
    logic [RW-1:0] rem_in    [SQRT_STAGES];
    logic [31:0]   root_in   [SQRT_STAGES];
    logic [63:0]   rad_in    [SQRT_STAGES];
    logic [RW+1:0] rem_sh    [SQRT_STAGES];
    logic [RW+1:0] trial     [SQRT_STAGES];
    logic [RW-1:0] rem_next  [SQRT_STAGES];
    logic [31:0]   root_next [SQRT_STAGES];
    logic [63:0]   rad_next  [SQRT_STAGES];

    always_comb
    begin
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            if (s == 0)
            begin
                rem_in[s]  = '0;
                root_in[s] = '0;
                rad_in[s]  = rad;
            end
            else
            begin
                rem_in[s]  = rem_reg[s-1];
                root_in[s] = root_reg[s-1];
                rad_in[s]  = rad_reg[s-1];
            end
            rem_sh[s] = {rem_in[s], rad_in[s][63:62]};
            trial[s]  = {2'b00, root_in[s], 2'b01};
            if (rem_sh[s] >= trial[s])
            begin
                rem_next[s]  = RW'(rem_sh[s] - trial[s]);
                root_next[s] = {root_in[s][30:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = RW'(rem_sh[s]);
                root_next[s] = {root_in[s][30:0], 1'b0};
            end
            rad_next[s] = {rad_in[s][61:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < SQRT_STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                rad_reg[s]  <= rad_next[s];
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

// ===== src/vau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// Depends on vau_pkg.
module vau_div import vau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] num,
    input  logic signed [32:0] den,
    output div_res_t           res
);

    localparam int QW = DATA_W + FRAC_BITS;

    logic [31:0]   nmag;
    logic [32:0]   dabs;
    logic [31:0]   rem_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [QW-1:0] dvd_reg  [QW];
    logic [31:0]   dmag_reg [QW];
    logic          neg_reg  [QW];
    logic          zero_reg [QW];
    logic          nneg_reg [QW];
    logic [31:0]   rem_in   [QW];
    logic [QW-1:0] quo_in   [QW];
    logic [QW-1:0] dvd_in   [QW];
    logic [31:0]   dmag_in  [QW];
    logic          neg_in   [QW];
    logic          zero_in  [QW];
    logic          nneg_in  [QW];
    logic [32:0]   rem_sh   [QW];
    logic          ge       [QW];
    logic [31:0]   rem_next [QW];
    logic [QW-1:0] q;

    always_comb
    begin
        nmag = num[31] ? (~num + 1'b1) : num;
        dabs = den[32] ? (~den + 1'b1) : den;
        for (int s = 0; s < QW; s++)
        begin
            if (s == 0)
            begin
                rem_in[s]  = '0;
                quo_in[s]  = '0;
                dvd_in[s]  = {nmag, {FRAC_BITS{1'b0}}};
                dmag_in[s] = dabs[31:0];
                neg_in[s]  = num[31] ^ den[32];
                zero_in[s] = (den == '0);
                nneg_in[s] = num[31];
            end
            else
            begin
                rem_in[s]  = rem_reg[s-1];
                quo_in[s]  = quo_reg[s-1];
                dvd_in[s]  = dvd_reg[s-1];
                dmag_in[s] = dmag_reg[s-1];
                neg_in[s]  = neg_reg[s-1];
                zero_in[s] = zero_reg[s-1];
                nneg_in[s] = nneg_reg[s-1];
            end
            rem_sh[s] = {rem_in[s], dvd_in[s][QW-1]};
            ge[s]     = (rem_sh[s] >= {1'b0, dmag_in[s]});
            if (ge[s])
                rem_next[s] = 32'(rem_sh[s] - {1'b0, dmag_in[s]});
            else
                rem_next[s] = rem_sh[s][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < QW; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= {quo_in[s][QW-2:0], ge[s]};
                dvd_reg[s]  <= {dvd_in[s][QW-2:0], 1'b0};
                dmag_reg[s] <= dmag_in[s];
                neg_reg[s]  <= neg_in[s];
                zero_reg[s] <= zero_in[s];
                nneg_reg[s] <= nneg_in[s];
            end
        end
    end

    always_comb
    begin
        q      = quo_reg[QW-1];
        res.dz = 1'b0;
        res.ov = 1'b0;
        if (zero_reg[QW-1])
        begin
            res.q  = nneg_reg[QW-1] ? S32_MIN : S32_MAX;
            res.dz = 1'b1;
        end
        else if (neg_reg[QW-1])
        begin
            if ((q[QW-1:32] != '0) || (q[31] && (q[30:0] != '0)))
            begin
                res.q  = S32_MIN;
                res.ov = 1'b1;
            end
            else
                res.q = ~q[31:0] + 1'b1;
        end
        else if (q[QW-1:31] != '0)
        begin
            res.q  = S32_MAX;
            res.ov = 1'b1;
        end
        else
            res.q = q[31:0];
    end

endmodule

// ===== src/vau_delay.sv =====
// Enabled shift line that carries an item's side data alongside a long pipeline.
// Depends on vau_pkg.
module vau_delay import vau_pkg::*; #(
    parameter int W     = DATA_W,
    parameter int DEPTH = SQRT_STAGES
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
                line_reg[i] <= line_reg[i-1];
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

// ===== src/vec3_arithmetic_unit.sv =====
// Top level of the three-component Q-format vector unit: lanes, root, dividers, merge.
// Depends on vau_pkg, vau_lane, vau_sqrt, vau_div and vau_delay.
//
// Usage:
//   Requests enter on s_tvalid/s_tready with the command in s_tuser and the
//   operands A, B and factor in s_tdata. One result leaves per request on
//   m_tvalid/m_tready, in order: rx, ry, rz, scalar_out in m_tdata and the
//   equal, divide-by-zero and overflow flags in m_tuser.
//   Each request passes the product and sum registers, 32 square-root
//   stages, 32 + FRAC_BITS divider stages and the output register. Every
//   command takes the same path length. Throughput is one request per
//   cycle; the whole pipeline advances together, so a request is taken in
//   any cycle where the output register is empty or being read.
//   When the receiver holds m_tready low with a result waiting, the pipeline
//   freezes and s_tready drops; nothing is lost.
//   Reset clears all valid bits; no result is pending afterward.
module vec3_arithmetic_unit import vau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,   // ax, ay, az, bx, by_comp, bz, factor
    input  logic [3:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // rx, ry, rz, scalar_out
    output logic [2:0]   m_tuser    // equal_flag, div_zero, overflow
);

    localparam int QW     = DATA_W + FRAC_BITS;
    localparam int PIPE_N = 2 + SQRT_STAGES + QW;

    typedef struct packed {
        cmd_t             cmd;
        logic [2:0][31:0] a;
        logic [2:0][31:0] den;
        sat_t [2:0]       lane;
        sat_t             dot;
        logic             eq;
    } side_a_t;

    typedef struct packed {
        cmd_t       cmd;
        sat_t [2:0] lane;
        sat_t       dot;
        logic       eq;
        sat_t       len;
        logic       len_zero;
    } side_b_t;

    logic               adv;
    cmd_t               cmd_in;
    logic signed [31:0] in_a [3];
    logic signed [31:0] in_b [3];
    logic signed [31:0] factor;
    logic signed [63:0] prod [3];
    sat_t               lane_res [3];

    cmd_t               cmd_p_reg;
    logic [2:0][31:0]   a_p_reg, den_p_reg, den_p_next;
    logic               eq_p_reg;

    logic signed [65:0] sum3;
    logic signed [65:0] dot_sh;
    cmd_t               cmd_s_reg;
    logic [2:0][31:0]   a_s_reg, den_s_reg;
    sat_t               dot_s_reg;
    logic               eq_s_reg;
    logic [63:0]        sumsq_s_reg;

    side_a_t            side_a_in, side_a_out;
    side_b_t            side_b_in, side_b_out;
    logic [31:0]        root;
    div_res_t           div_res [3];

    logic [PIPE_N-1:0]  vld_reg;
    logic               out_valid_reg;
    logic [127:0]       m_data_reg, m_data_next;
    logic [2:0]         m_user_reg, m_user_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign cmd_in   = cmd_t'(s_tuser);
    assign factor   = s_tdata[223:192];

    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++)
        begin : g_lane
            assign in_a[gi] = s_tdata[32*gi +: 32];
            assign in_b[gi] = s_tdata[96 + 32*gi +: 32];

            vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .clk  (clk),
                .en   (adv),
                .cmd  (cmd_in),
                .ai   (in_a[gi]),
                .bi   (in_b[gi]),
                .aj   (in_a[(gi+1)%3]),
                .bj   (in_b[(gi+1)%3]),
                .am   (in_a[(gi+2)%3]),
                .bm   (in_b[(gi+2)%3]),
                .k    (factor),
                .prod (prod[gi]),
                .res  (lane_res[gi])
            );

            assign side_a_in.a[gi]    = a_s_reg[gi];
            assign side_a_in.den[gi]  = den_s_reg[gi];
            assign side_a_in.lane[gi] = lane_res[gi];
            assign side_b_in.lane[gi] = side_a_out.lane[gi];

            vau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
                .clk (clk),
                .en  (adv),
                .num (side_a_out.a[gi]),
                .den ((side_a_out.cmd == CMD_NORMALIZE) ? {1'b0, root}
                                                        : {side_a_out.den[gi][31],
                                                           side_a_out.den[gi]}),
                .res (div_res[gi])
            );
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            den_p_next[i] = (cmd_in == CMD_DIVSCALAR) ? factor : in_b[i];
        sum3   = 66'(prod[0]) + 66'(prod[1]) + 66'(prod[2]);
        dot_sh = sum3 >>> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_p_reg   <= cmd_in;
            a_p_reg     <= s_tdata[95:0];
            den_p_reg   <= den_p_next;
            eq_p_reg    <= (s_tdata[95:0] == s_tdata[191:96]);
            cmd_s_reg   <= cmd_p_reg;
            a_s_reg     <= a_p_reg;
            den_s_reg   <= den_p_reg;
            eq_s_reg    <= eq_p_reg;
            dot_s_reg   <= sat65(dot_sh[64:0]);
            sumsq_s_reg <= sum3[63:0];
        end
    end

    assign side_a_in.cmd = cmd_s_reg;
    assign side_a_in.dot = dot_s_reg;
    assign side_a_in.eq  = eq_s_reg;

    vau_delay #(.W($bits(side_a_t)), .DEPTH(SQRT_STAGES)) u_delay_a (
        .clk  (clk),
        .en   (adv),
        .din  (side_a_in),
        .dout (side_a_out)
    );

    vau_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (sumsq_s_reg),
        .root (root)
    );

    assign side_b_in.cmd      = side_a_out.cmd;
    assign side_b_in.dot      = side_a_out.dot;
    assign side_b_in.eq       = side_a_out.eq;
    assign side_b_in.len.val  = root[31] ? S32_MAX : root;
    assign side_b_in.len.ov   = root[31];
    assign side_b_in.len_zero = (root == '0);

    vau_delay #(.W($bits(side_b_t)), .DEPTH(QW)) u_delay_b (
        .clk  (clk),
        .en   (adv),
        .din  (side_b_in),
        .dout (side_b_out)
    );

    always_comb
    begin
        m_data_next = '0;
        m_user_next = '0;
        case (side_b_out.cmd)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_CROSS, CMD_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_data_next[32*i +: 32] = side_b_out.lane[i].val;
                    m_user_next[2] = m_user_next[2] | side_b_out.lane[i].ov;
                end
            end
            CMD_DIV, CMD_DIVSCALAR, CMD_NORMALIZE:
            begin
                if (!(side_b_out.cmd == CMD_NORMALIZE && side_b_out.len_zero))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_data_next[32*i +: 32] = div_res[i].q;
                        m_user_next[1] = m_user_next[1] | div_res[i].dz;
                        m_user_next[2] = m_user_next[2] | div_res[i].ov;
                    end
                end
            end
            CMD_DOT:
            begin
                m_data_next[127:96] = side_b_out.dot.val;
                m_user_next[2]      = side_b_out.dot.ov;
            end
            CMD_LENGTH:
            begin
                m_data_next[127:96] = side_b_out.len.val;
                m_user_next[2]      = side_b_out.len.ov;
            end
            CMD_EQUAL:
                m_user_next[0] = side_b_out.eq;
            default:
                m_data_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[PIPE_N-2:0], s_tvalid};
            out_valid_reg <= vld_reg[PIPE_N-1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_equal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1] && !m_tuser[2])
        else $error("equal result carries data or flags");

    a_dz_no_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> (m_tdata[127:96] == '0))
        else $error("divide-by-zero result with scalar output");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ===== bench/tb_vec3_arithmetic_unit.sv =====
// Testbench for vec3_arithmetic_unit: directed and random vector requests with
// random idling on both stream sides, checked in order against a local predictor.
// Depends on vau_pkg and the vec3_arithmetic_unit RTL.
`timescale 1ns / 1ps

module tb_vec3_arithmetic_unit import vau_pkg::*;;

    localparam int FRAC       = 16;
    localparam int N_RANDOM   = 2000;
    localparam int QUIET_TAIL = 200;
    localparam int DRAIN_AT   = 1000;
    localparam int CYCLE_MAX  = 400000;

    typedef struct {
        logic [3:0]         cmd;
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic signed [31:0] k;
        bit                 drain;
    } vec_req_t;

    typedef struct {
        logic signed [31:0] r [3];
        logic signed [31:0] sc;
        logic               eq;
        logic               dz;
        logic               ov;
    } vec_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;   // ax, ay, az, bx, by_comp, bz, factor
    logic [3:0]   s_tuser;   // command
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // rx, ry, rz, scalar_out
    logic [2:0]   m_tuser;   // equal_flag, div_zero, overflow

    vec_req_t pending_reqs [$];
    vec_res_t expected_res [$];
    vec_req_t cur_req;
    int       total_reqs;
    int       sent_count;
    int       send_gap;
    int       recv_gap;
    int       cycle_count;
    bit       failed;

    vec3_arithmetic_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic signed [31:0] sat_val(input logic signed [65:0] v, inout logic ov);
        if (v > 66'sd2147483647)
        begin
            ov = 1'b1;
            return S32_MAX;
        end
        if (v < -66'sd2147483648)
        begin
            ov = 1'b1;
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] q_div(input longint n, input longint d,
                                                 inout logic dz, inout logic ov);
        longint q;
        if (d == 0)
        begin
            dz = 1'b1;
            return (n < 0) ? S32_MIN : S32_MAX;
        end
        q = (n * (64'sd1 <<< FRAC)) / d;
        return sat_val(66'(q), ov);
    endfunction

    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned r;
        longint unsigned bitv;
        r    = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= r + bitv)
            begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic vec_res_t predict_vec(input vec_req_t q);
        vec_res_t          res;
        logic signed [65:0] acc;
        longint unsigned   sq;
        longint unsigned   len;
        longint            m;
        int                j;
        int                n;
        res.r[0] = 0;
        res.r[1] = 0;
        res.r[2] = 0;
        res.sc   = 0;
        res.eq   = 0;
        res.dz   = 0;
        res.ov   = 0;
        case (q.cmd)
            CMD_ADD:
                for (int i = 0; i < 3; i++)
                    res.r[i] = sat_val(66'(q.a[i]) + 66'(q.b[i]), res.ov);
            CMD_SUB:
                for (int i = 0; i < 3; i++)
                    res.r[i] = sat_val(66'(q.a[i]) - 66'(q.b[i]), res.ov);
            CMD_MUL:
                for (int i = 0; i < 3; i++)
                    res.r[i] = sat_val((66'(q.a[i]) * 66'(q.b[i])) >>> FRAC, res.ov);
            CMD_DIV:
                for (int i = 0; i < 3; i++)
                    res.r[i] = q_div(q.a[i], q.b[i], res.dz, res.ov);
            CMD_DOT:
            begin
                acc = 0;
                for (int i = 0; i < 3; i++)
                    acc = acc + 66'(q.a[i]) * 66'(q.b[i]);
                res.sc = sat_val(acc >>> FRAC, res.ov);
            end
            CMD_CROSS:
                for (int i = 0; i < 3; i++)
                begin
                    j   = (i + 1) % 3;
                    n   = (i + 2) % 3;
                    acc = 66'(q.a[j]) * 66'(q.b[n]) - 66'(q.a[n]) * 66'(q.b[j]);
                    res.r[i] = sat_val(acc >>> FRAC, res.ov);
                end
            CMD_SCALE:
                for (int i = 0; i < 3; i++)
                    res.r[i] = sat_val((66'(q.a[i]) * 66'(q.k)) >>> FRAC, res.ov);
            CMD_DIVSCALAR:
                for (int i = 0; i < 3; i++)
                    res.r[i] = q_div(q.a[i], q.k, res.dz, res.ov);
            CMD_LENGTH, CMD_NORMALIZE:
            begin
                sq = 0;
                for (int i = 0; i < 3; i++)
                begin
                    m  = (q.a[i] < 0) ? -longint'(q.a[i]) : longint'(q.a[i]);
                    sq = sq + longint'(m) * longint'(m);
                end
                len = root64(sq);
                if (q.cmd == CMD_LENGTH)
                    res.sc = sat_val(66'(len), res.ov);
                else if (len == 0)
                    for (int i = 0; i < 3; i++)
                        res.r[i] = q.a[i];
                else
                    for (int i = 0; i < 3; i++)
                        res.r[i] = q_div(q.a[i], longint'(len), res.dz, res.ov);
            end
            CMD_EQUAL:
                res.eq = (q.a[0] == q.b[0]) && (q.a[1] == q.b[1]) && (q.a[2] == q.b[2]);
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000) - 32'sh0002_0000;
            2: return $urandom_range(0, 32'h0100_0000) - 32'sh0080_0000;
            3: return 0;
            4: return ($urandom_range(0, 1)) ? S32_MAX : S32_MIN;
            default: return $signed($urandom) >>> $urandom_range(0, 30);
        endcase
    endfunction

    function automatic vec_req_t make_req(input logic [3:0] cmd,
                                          input logic signed [31:0] v, input logic signed [31:0] w,
                                          input logic signed [31:0] k);
        vec_req_t q;
        q.cmd = cmd;
        for (int i = 0; i < 3; i++)
        begin
            q.a[i] = v;
            q.b[i] = w;
        end
        q.k     = k;
        q.drain = 0;
        return q;
    endfunction

    task automatic add_req(input vec_req_t q);
        pending_reqs.push_back(q);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            sent_count <= 0;
            send_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_res.push_back(predict_vec(cur_req));
                sent_count <= sent_count + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].drain && expected_res.size() != 0))
                    s_tvalid <= 1'b0;
                else
                begin
                    cur_req  = pending_reqs.pop_front();
                    s_tdata  <= {cur_req.k, cur_req.b[2], cur_req.b[1], cur_req.b[0],
                                 cur_req.a[2], cur_req.a[1], cur_req.a[0]};
                    s_tuser  <= cur_req.cmd;
                    s_tvalid <= 1'b1;
                    if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 10);
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_res.size() == 0)
                begin
                    $display("%t unexpected result %h %h", $time, m_tdata, m_tuser);
                    failed = 1;
                end
                else
                begin
                    vec_res_t e;
                    e = expected_res.pop_front();
                    if (m_tdata[31:0] !== e.r[0])
                    begin
                        $display("%t rx expected %h actual %h", $time, e.r[0], m_tdata[31:0]);
                        failed = 1;
                    end
                    if (m_tdata[63:32] !== e.r[1])
                    begin
                        $display("%t ry expected %h actual %h", $time, e.r[1], m_tdata[63:32]);
                        failed = 1;
                    end
                    if (m_tdata[95:64] !== e.r[2])
                    begin
                        $display("%t rz expected %h actual %h", $time, e.r[2], m_tdata[95:64]);
                        failed = 1;
                    end
                    if (m_tdata[127:96] !== e.sc)
                    begin
                        $display("%t scalar_out expected %h actual %h", $time, e.sc,
                                 m_tdata[127:96]);
                        failed = 1;
                    end
                    if (m_tuser[0] !== e.eq)
                    begin
                        $display("%t equal_flag expected %b actual %b", $time, e.eq, m_tuser[0]);
                        failed = 1;
                    end
                    if (m_tuser[1] !== e.dz)
                    begin
                        $display("%t div_zero expected %b actual %b", $time, e.dz, m_tuser[1]);
                        failed = 1;
                    end
                    if (m_tuser[2] !== e.ov)
                    begin
                        $display("%t overflow expected %b actual %b", $time, e.ov, m_tuser[2]);
                        failed = 1;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end
            else if (total_reqs - sent_count > QUIET_TAIL && $urandom_range(0, 7) == 0)
            begin
                recv_gap <= $urandom_range(0, 9);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX)
        begin
            $display("FAIL vec3_arithmetic_unit");
            $finish;
        end
    end

    initial
    begin
        vec_req_t q;
        clk         = 0;
        rst_n       = 0;
        failed      = 0;
        cycle_count = 0;
        total_reqs  = 1 << 30;

        add_req(make_req(CMD_ADD, S32_MAX, S32_MAX, 0));
        add_req(make_req(CMD_ADD, S32_MIN, S32_MIN, 0));
        add_req(make_req(CMD_SUB, S32_MIN, S32_MAX, 0));
        add_req(make_req(CMD_SUB, S32_MAX, -1, 0));
        add_req(make_req(CMD_MUL, S32_MIN, S32_MIN, 0));
        add_req(make_req(CMD_MUL, -32'sd1, 32'sd1, 0));
        add_req(make_req(CMD_DIV, -32'sd5, 0, 0));
        add_req(make_req(CMD_DIV, 0, 0, 0));
        add_req(make_req(CMD_DIV, S32_MIN, -32'sd1, 0));
        add_req(make_req(CMD_DOT, S32_MIN, S32_MIN, 0));
        add_req(make_req(CMD_DOT, S32_MAX, S32_MIN, 0));
        add_req(make_req(CMD_CROSS, S32_MAX, S32_MIN, 0));
        add_req(make_req(CMD_SCALE, S32_MAX, 0, S32_MIN));
        add_req(make_req(CMD_SCALE, 32'sh0001_8000, 0, -32'sh0000_8000));
        add_req(make_req(CMD_DIVSCALAR, -32'sd7, 0, 0));
        add_req(make_req(CMD_DIVSCALAR, S32_MAX, 0, 32'sd1));
        add_req(make_req(CMD_LENGTH, S32_MIN, 0, 0));
        add_req(make_req(CMD_LENGTH, 0, 0, 0));
        add_req(make_req(CMD_NORMALIZE, 0, 0, 0));
        add_req(make_req(CMD_NORMALIZE, S32_MIN, 0, 0));
        add_req(make_req(CMD_NORMALIZE, 32'sd1, 0, 0));
        add_req(make_req(CMD_EQUAL, S32_MIN, S32_MIN, 0));
        add_req(make_req(CMD_EQUAL, 32'sd3, 32'sd4, 0));
        add_req(make_req(4'd11, S32_MAX, S32_MIN, S32_MAX));
        add_req(make_req(4'd15, -1, -1, -1));

        for (int n = 0; n < N_RANDOM; n++)
        begin
            q.cmd = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15))
                                                 : 4'($urandom_range(0, 10));
            for (int i = 0; i < 3; i++)
            begin
                q.a[i] = rand_operand();
                q.b[i] = rand_operand();
            end
            q.k = rand_operand();
            if (q.cmd == CMD_EQUAL && $urandom_range(0, 1))
            begin
                q.b[0] = q.a[0];
                q.b[1] = q.a[1];
                q.b[2] = q.a[2];
                if ($urandom_range(0, 1))
                    q.b[$urandom_range(0, 2)] ^= 32'd1 << $urandom_range(0, 31);
            end
            q.drain = (n == DRAIN_AT);
            add_req(q);
        end
        total_reqs = pending_reqs.size();

        repeat (6) @(posedge clk);
        rst_n = 1;

        wait (sent_count == total_reqs && expected_res.size() == 0);
        repeat (120) @(posedge clk);
        if (!failed && expected_res.size() == 0)
            $display("PASS vec3_arithmetic_unit");
        else
            $display("FAIL vec3_arithmetic_unit");
        $finish;
    end

endmodule
